FILE: rtl/kop_pkg.sv
// Shared types, constants and tables of the Kepler orbit position block.
// Depends on nothing; compile first.
package kop_pkg;

    localparam int ANGLE_BITS = 24;
    localparam int FRAC_BITS  = 24;

    localparam int ASHIFT = 32 - ANGLE_BITS;
    localparam int E_SHR  = (FRAC_BITS >= 30) ? FRAC_BITS - 30 : 0;
    localparam int E_SHL  = (FRAC_BITS >= 30) ? 0 : 30 - FRAC_BITS;

    localparam logic [31:0] ANG_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
    localparam logic [23:0] ECC_MAX  =
        (FRAC_BITS >= 24) ? 24'hFFFFFF : 24'((64'd1 << FRAC_BITS) - 64'd1);

    localparam int VAL_W = 36;
    localparam int MUL_W = 34;
    localparam int PRD_W = 2 * MUL_W;

    localparam int CORDIC_STEPS = 30;
    localparam int DIV_STEPS    = 62;
    localparam int SQRT_STEPS   = 32;

    localparam logic signed [VAL_W-1:0] ONE_Q30      = 36'sd1073741824;
    localparam logic signed [VAL_W-1:0] CORDIC_START = 36'sd652032874;
    localparam logic signed [VAL_W-1:0] RAD_TO_TURN  = 36'sd683565276;
    localparam logic signed [VAL_W-1:0] QUARTER_TURN = 36'sd1073741824;
    localparam logic signed [VAL_W-1:0] HALF_TURN    = 36'sd2147483648;
    localparam logic signed [39:0]      POS_MAX      = 40'sd4294967295;

    typedef enum logic [1:0] {
        REG_NEWTON_THRESHOLD = 2'd0,
        REG_CONVERGE_LIMIT   = 2'd1,
        REG_MAX_ITERATIONS   = 2'd2
    } reg_idx_t;

    typedef enum logic [5:0] {
        ST_IDLE, ST_CWAIT,
        ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5,
        ST_N0, ST_N1, ST_N2, ST_N3, ST_DIV, ST_N4,
        ST_F0, ST_F1, ST_SQ, ST_F2, ST_F3, ST_F4, ST_F5, ST_F6, ST_F7,
        ST_F8, ST_F9, ST_F10, ST_F11, ST_F12, ST_F13, ST_F14, ST_F15,
        ST_F16, ST_DONE
    } state_t;

    typedef struct packed {
        logic                    start;
        logic                    vectoring;
        logic [31:0]             ang;
        logic signed [VAL_W-1:0] vx;
        logic signed [VAL_W-1:0] vy;
    } cordic_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [VAL_W-1:0] sin;
        logic signed [VAL_W-1:0] cos;
        logic [31:0]             ang;
    } cordic_rsp_t;

    // atan(2^-i) in 2^-32 turn units
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/kop_in_if.sv
// Input channel of the orbit position block: valid/ready plus orbital elements.
// No dependencies.
interface kop_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] mean_anomaly;
    logic [23:0] eccentricity;
    logic [31:0] semi_major_axis;
    logic [23:0] node_longitude;
    logic [23:0] inclination;
    logic [23:0] periapsis_argument;

    modport source (output valid, mean_anomaly, eccentricity, semi_major_axis,
                    node_longitude, inclination, periapsis_argument,
                    input ready);
    modport sink (input valid, mean_anomaly, eccentricity, semi_major_axis,
                  node_longitude, inclination, periapsis_argument,
                  output ready);
endinterface

FILE: rtl/kop_out_if.sv
// Output channel of the orbit position block: valid/ready plus solved position.
// No dependencies.
interface kop_out_if;
    logic               valid;
    logic               ready;
    logic [23:0]        eccentric_anomaly;
    logic [23:0]        true_anomaly;
    logic [32:0]        radius;
    logic signed [32:0] pos_x;
    logic signed [32:0] pos_y;
    logic signed [32:0] pos_z;

    modport source (output valid, eccentric_anomaly, true_anomaly, radius,
                    pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, eccentric_anomaly, true_anomaly, radius,
                  pos_x, pos_y, pos_z, output ready);
endinterface

FILE: rtl/kop_cordic.sv
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// Depends on kop_pkg.
module kop_cordic (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kop_pkg::cordic_req_t req,
    output kop_pkg::cordic_rsp_t rsp
);
    import kop_pkg::*;

    logic                    busy_reg;
    logic                    done_reg;
    logic [4:0]              step_reg;
    logic                    vec_reg;
    logic                    neg_reg;
    logic                    zero_reg;
    logic signed [VAL_W-1:0] x_reg, y_reg, z_reg;

    logic signed [VAL_W-1:0] xs, ys, at, x_step, y_step, z_step;
    logic signed [VAL_W-1:0] z_fold;
    logic                    dn, fold_neg;

    always_comb
    begin
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        at = $signed({4'b0, atan_turn(step_reg)});
        dn = vec_reg ? !(y_reg > 0) : (z_reg >= 0);
        x_step = dn ? x_reg - ys : x_reg + ys;
        y_step = dn ? y_reg + xs : y_reg - xs;
        z_step = dn ? z_reg - at : z_reg + at;

        // fold the angle into +-1/4 turn
        z_fold   = VAL_W'($signed(req.ang));
        fold_neg = 1'b0;
        if (z_fold > QUARTER_TURN)
        begin
            z_fold   = z_fold - HALF_TURN;
            fold_neg = 1'b1;
        end
        else if (z_fold < -QUARTER_TURN)
        begin
            z_fold   = z_fold + HALF_TURN;
            fold_neg = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == 5'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            vec_reg <= req.vectoring;
            if (req.vectoring)
            begin
                neg_reg  <= 1'b0;
                zero_reg <= (req.vx == 0) && (req.vy == 0);
                if (req.vx < 0)
                begin
                    x_reg <= -req.vx;
                    y_reg <= -req.vy;
                    z_reg <= HALF_TURN;
                end
                else
                begin
                    x_reg <= req.vx;
                    y_reg <= req.vy;
                    z_reg <= '0;
                end
            end
            else
            begin
                zero_reg <= 1'b0;
                neg_reg  <= fold_neg;
                x_reg    <= CORDIC_START;
                y_reg    <= '0;
                z_reg    <= z_fold;
            end
        end
        else if (busy_reg)
        begin
            x_reg <= x_step;
            y_reg <= y_step;
            z_reg <= z_step;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.sin  = neg_reg ? -y_reg : y_reg;
    assign rsp.cos  = neg_reg ? -x_reg : x_reg;
    assign rsp.ang  = zero_reg ? 32'd0 : z_reg[31:0];

endmodule

FILE: rtl/kepler_orbit_position.sv
// Top level of the Kepler orbit position block: sequencer, shared multiplier,
// divider and square root. Depends on kop_pkg, kop_in_if, kop_out_if, kop_cordic.
//
// One transaction of orbital elements yields one transaction of eccentric and
// true anomaly, radius and x/y/z position. The block handles one item at a
// time: elements.ready is high only while the sequencer is idle. Newton
// refinement, when it runs, takes up to max_iterations steps (the reset cap
// is ten). Each CORDIC call (six per item, one more per Newton step) is
// issued and then waits on the shared one-rotation-per-cycle CORDIC unit.
// Each Newton step also runs the radix-2 divider, and every item runs the
// square root. A finished result waits in the output register while the
// next item is accepted and worked on; a result that is still not taken
// when the next one finishes stalls the sequencer.
// Configuration goes through the APB port (pready is always high); write it
// only while the block is idle.
module kepler_orbit_position (
    input  logic        clk,
    input  logic        rst_n,
    kop_in_if.sink      elements,
    kop_out_if.source   position,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import kop_pkg::*;

    // configuration
    logic [23:0] thr_reg;
    logic [15:0] lim_cfg_reg;
    logic [3:0]  maxit_reg;

    // sequencer
    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic   out_vld_reg;

    // latched elements
    logic [31:0] m_reg, node_reg, incl_reg, peri_reg, a_reg;
    logic [23:0] ecc_reg;

    // working values
    logic signed [VAL_W-1:0] s_reg, c_reg;
    logic [31:0]             ang_reg;
    logic signed [VAL_W-1:0] se_reg, ce_reg, sl_reg, cl_reg, sn_reg, cn_reg;
    logic signed [VAL_W-1:0] p_reg, t_reg, f_reg, g_reg, slci_reg;
    logic signed [VAL_W-1:0] t1_reg, dx_reg, dy_reg, dz_reg;
    logic [31:0]             ea_reg, e0_reg, nu_reg;
    logic [3:0]              k_reg;
    logic [5:0]              cnt_reg;
    logic [32:0]             rad_reg;
    logic signed [32:0]      px_reg, py_reg, pz_reg;

    // divider and square root
    logic [30:0] d_reg;
    logic [30:0] rem_reg;
    logic [61:0] dv_reg;
    logic        fneg_reg;
    logic [63:0] sv_reg, sr_reg, sbit_reg;

    // multiplier
    logic                    mul_en;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [PRD_W-1:0] prod_reg;
    logic signed [VAL_W-1:0] q30;
    logic signed [39:0]      q28;

    // result register
    logic [23:0]        res_ea_reg, res_nu_reg;
    logic [32:0]        res_rad_reg;
    logic signed [32:0] res_px_reg, res_py_reg, res_pz_reg;

    cordic_req_t creq;
    cordic_rsp_t crsp;

    logic                    accept, cfg_write, newton, conv, last_step;
    logic [30:0]             e30;
    logic signed [VAL_W-1:0] e30s, st, fa, dtmp, gtmp, stmp;
    logic [31:0]             ea_p, ea_n, lon;
    logic [31:0]             trial;
    logic                    ge;
    logic [63:0]             sq_sum;
    logic [39:0]             lim;

    function automatic logic signed [MUL_W-1:0] mop(input logic signed [VAL_W-1:0] v);
        return $signed(v[MUL_W-1:0]);
    endfunction

    function automatic logic [32:0] rad_sat(input logic [PRD_W-1:0] p);
        if (|p[PRD_W-1:63])
            return '1;
        return p[62:30];
    endfunction

    function automatic logic signed [32:0] pos_sat(input logic signed [39:0] v);
        if (v > POS_MAX)
            return 33'(POS_MAX);
        if (v < -POS_MAX)
            return 33'(-POS_MAX);
        return 33'(v);
    endfunction

    kop_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (creq),
        .rsp   (crsp)
    );

    // ---------------------------------------------------------------
    // Shared combinational terms
    // ---------------------------------------------------------------
    assign accept    = elements.valid && elements.ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign e30       = 31'((31'(ecc_reg) >> E_SHR) << E_SHL);
    assign e30s      = $signed({5'b0, e30});
    assign q30       = $signed(prod_reg[VAL_W+29:30]);
    assign q28       = $signed(prod_reg[67:28]);
    assign lim       = 40'(lim_cfg_reg) << ASHIFT;
    assign newton    = (ecc_reg > thr_reg) && (maxit_reg != 4'd0);

    always_comb
    begin
        ea_p = m_reg + q30[31:0];
        st   = VAL_W'($signed(e0_reg - m_reg));
        fa   = f_reg[VAL_W-1] ? -f_reg : f_reg;
        dtmp = ONE_Q30 - q30;
        gtmp = ONE_Q30 - q30;
        stmp = ONE_Q30 - q30;
        ea_n = fneg_reg ? e0_reg + dv_reg[31:0] : e0_reg - dv_reg[31:0];
        conv = dv_reg < 62'(lim);
        last_step = (5'(k_reg) + 5'd1) == 5'(maxit_reg);
        lon  = ang_reg + peri_reg;
        trial = {rem_reg, dv_reg[61]};
        ge    = trial >= {1'b0, d_reg};
        sq_sum = sr_reg + sbit_reg;
    end

    // ---------------------------------------------------------------
    // Multiplier operand select; the product register holds otherwise
    // ---------------------------------------------------------------
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_P0, ST_N0:
            begin
                mul_en = 1'b1; mul_a = mop(e30s); mul_b = mop(s_reg);
            end
            ST_P1, ST_N2:
            begin
                mul_en = 1'b1; mul_a = mop(e30s); mul_b = mop(c_reg);
            end
            ST_P3:
            begin
                mul_en = 1'b1; mul_a = mop(p_reg); mul_b = mop(t_reg);
            end
            ST_P4, ST_N1:
            begin
                mul_en = 1'b1; mul_a = mop(q30); mul_b = mop(RAD_TO_TURN);
            end
            ST_F0:
            begin
                mul_en = 1'b1; mul_a = mop(e30s); mul_b = mop(e30s);
            end
            ST_F2:
            begin
                mul_en = 1'b1;
                mul_a  = mop($signed({3'b0, sr_reg[32:0]}));
                mul_b  = mop(se_reg);
            end
            ST_F3:
            begin
                mul_en = 1'b1; mul_a = mop(e30s); mul_b = mop(ce_reg);
            end
            ST_F5:
            begin
                mul_en = 1'b1; mul_a = mop($signed({4'b0, a_reg})); mul_b = mop(g_reg);
            end
            ST_F7:
            begin
                mul_en = 1'b1; mul_a = mop(sl_reg); mul_b = mop(c_reg);
            end
            ST_F8:
            begin
                mul_en = 1'b1; mul_a = mop(cn_reg); mul_b = mop(cl_reg);
            end
            ST_F9:
            begin
                mul_en = 1'b1; mul_a = mop(sn_reg); mul_b = mop(slci_reg);
            end
            ST_F10:
            begin
                mul_en = 1'b1; mul_a = mop(sn_reg); mul_b = mop(cl_reg);
            end
            ST_F11:
            begin
                mul_en = 1'b1; mul_a = mop(cn_reg); mul_b = mop(slci_reg);
            end
            ST_F12:
            begin
                mul_en = 1'b1; mul_a = mop(sl_reg); mul_b = mop(s_reg);
            end
            ST_F13:
            begin
                mul_en = 1'b1;
                mul_a  = mop($signed({3'b0, rad_reg}));
                mul_b  = mop(dx_reg >>> 2);
            end
            ST_F14:
            begin
                mul_en = 1'b1;
                mul_a  = mop($signed({3'b0, rad_reg}));
                mul_b  = mop(dy_reg >>> 2);
            end
            ST_F15:
            begin
                mul_en = 1'b1;
                mul_a  = mop($signed({3'b0, rad_reg}));
                mul_b  = mop(dz_reg >>> 2);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= mul_a * mul_b;
    end

    // ---------------------------------------------------------------
    // Sequencer: next state and CORDIC requests
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        creq       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (elements.valid)
                begin
                    // rotate the mean anomaly for the first estimate
                    creq.start = 1'b1;
                    creq.ang   = (32'(elements.mean_anomaly) & ANG_MASK) << ASHIFT;
                    ret_next   = ST_P0;
                    state_next = ST_CWAIT;
                end
            end
            ST_CWAIT:
            begin
                if (crsp.done)
                    state_next = ret_reg;
            end
            ST_P0:  state_next = ST_P1;
            ST_P1:  state_next = ST_P2;
            ST_P2:  state_next = ST_P3;
            ST_P3:  state_next = ST_P4;
            ST_P4:  state_next = ST_P5;
            ST_P5:
            begin
                creq.start = 1'b1;
                creq.ang   = ea_p;
                ret_next   = newton ? ST_N0 : ST_F0;
                state_next = ST_CWAIT;
            end
            ST_N0:  state_next = ST_N1;
            ST_N1:  state_next = ST_N2;
            ST_N2:  state_next = ST_N3;
            ST_N3:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == 6'(DIV_STEPS - 1))
                    state_next = ST_N4;
            end
            ST_N4:
            begin
                // the next CORDIC call serves either the next step or the finish
                creq.start = 1'b1;
                creq.ang   = ea_n;
                ret_next   = (conv || last_step) ? ST_F0 : ST_N0;
                state_next = ST_CWAIT;
            end
            ST_F0:  state_next = ST_F1;
            ST_F1:  state_next = ST_SQ;
            ST_SQ:
            begin
                if (cnt_reg == 6'(SQRT_STEPS - 1))
                    state_next = ST_F2;
            end
            ST_F2:  state_next = ST_F3;
            ST_F3:
            begin
                creq.start     = 1'b1;
                creq.vectoring = 1'b1;
                creq.vx        = ce_reg - e30s;
                creq.vy        = q30;
                ret_next       = ST_F4;
                state_next     = ST_CWAIT;
            end
            ST_F4:
            begin
                creq.start = 1'b1;
                creq.ang   = lon;
                ret_next   = ST_F5;
                state_next = ST_CWAIT;
            end
            ST_F5:
            begin
                creq.start = 1'b1;
                creq.ang   = node_reg;
                ret_next   = ST_F6;
                state_next = ST_CWAIT;
            end
            ST_F6:
            begin
                creq.start = 1'b1;
                creq.ang   = incl_reg;
                ret_next   = ST_F7;
                state_next = ST_CWAIT;
            end
            ST_F7:  state_next = ST_F8;
            ST_F8:  state_next = ST_F9;
            ST_F9:  state_next = ST_F10;
            ST_F10: state_next = ST_F11;
            ST_F11: state_next = ST_F12;
            ST_F12: state_next = ST_F13;
            ST_F13: state_next = ST_F14;
            ST_F14: state_next = ST_F15;
            ST_F15: state_next = ST_F16;
            ST_F16: state_next = ST_DONE;
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_vld_reg || position.ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            out_vld_reg <= 1'b0;
            thr_reg     <= 24'd838861;
            lim_cfg_reg <= 16'd47;
            maxit_reg   <= 4'd10;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            if (state_reg == ST_DONE && (!out_vld_reg || position.ready))
                out_vld_reg <= 1'b1;
            else if (position.ready)
                out_vld_reg <= 1'b0;
            if (cfg_write)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_NEWTON_THRESHOLD: thr_reg     <= pwdata[23:0];
                    REG_CONVERGE_LIMIT:   lim_cfg_reg <= pwdata[15:0];
                    REG_MAX_ITERATIONS:   maxit_reg   <= pwdata[3:0];
                    default: ;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    m_reg    <= (32'(elements.mean_anomaly) & ANG_MASK) << ASHIFT;
                    node_reg <= (32'(elements.node_longitude) & ANG_MASK) << ASHIFT;
                    incl_reg <= (32'(elements.inclination) & ANG_MASK) << ASHIFT;
                    peri_reg <= (32'(elements.periapsis_argument) & ANG_MASK) << ASHIFT;
                    a_reg    <= elements.semi_major_axis;
                    ecc_reg  <= (elements.eccentricity > ECC_MAX) ? ECC_MAX
                                                                  : elements.eccentricity;
                end
            end
            ST_CWAIT:
            begin
                if (crsp.done)
                begin
                    s_reg   <= crsp.sin;
                    c_reg   <= crsp.cos;
                    ang_reg <= crsp.ang;
                end
            end
            ST_P1: p_reg <= q30;
            ST_P2: t_reg <= ONE_Q30 + q30;
            ST_P5:
            begin
                ea_reg <= ea_p;
                e0_reg <= ea_p;
                k_reg  <= '0;
            end
            ST_N2: f_reg <= st - q30;
            ST_N3:
            begin
                // flat slope: raise the denominator to one unit
                d_reg    <= (dtmp < 1) ? 31'd1 : dtmp[30:0];
                fneg_reg <= f_reg[VAL_W-1];
                dv_reg   <= {fa[31:0], 30'b0};
                rem_reg  <= '0;
                cnt_reg  <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= ge ? 31'(trial - {1'b0, d_reg}) : trial[30:0];
                dv_reg  <= {dv_reg[60:0], ge};
                cnt_reg <= cnt_reg + 6'd1;
            end
            ST_N4:
            begin
                ea_reg <= ea_n;
                e0_reg <= ea_n;
                k_reg  <= k_reg + 4'd1;
            end
            ST_F0:
            begin
                se_reg <= s_reg;
                ce_reg <= c_reg;
            end
            ST_F1:
            begin
                sv_reg   <= 64'(stmp[30:0]) << 30;
                sr_reg   <= '0;
                sbit_reg <= 64'd1 << 62;
                cnt_reg  <= '0;
            end
            ST_SQ:
            begin
                if (sv_reg >= sq_sum)
                begin
                    sv_reg <= sv_reg - sq_sum;
                    sr_reg <= (sr_reg >> 1) + sbit_reg;
                end
                else
                    sr_reg <= sr_reg >> 1;
                sbit_reg <= sbit_reg >> 2;
                cnt_reg  <= cnt_reg + 6'd1;
            end
            ST_F4:
            begin
                nu_reg <= ang_reg;
                // negative radius factor reads as zero
                g_reg  <= (gtmp < 0) ? '0 : gtmp;
            end
            ST_F5:
            begin
                sl_reg <= s_reg;
                cl_reg <= c_reg;
            end
            ST_F6:
            begin
                sn_reg  <= s_reg;
                cn_reg  <= c_reg;
                rad_reg <= rad_sat(prod_reg);
            end
            ST_F8:  slci_reg <= q30;
            ST_F9:  t1_reg   <= q30;
            ST_F10: dx_reg   <= t1_reg - q30;
            ST_F11: t1_reg   <= q30;
            ST_F12: dy_reg   <= t1_reg + q30;
            ST_F13: dz_reg   <= q30;
            ST_F14: px_reg   <= pos_sat(q28);
            ST_F15: py_reg   <= pos_sat(q28);
            ST_F16: pz_reg   <= pos_sat(q28);
            ST_DONE:
            begin
                if (!out_vld_reg || position.ready)
                begin
                    res_ea_reg  <= 24'(ea_reg >> ASHIFT);
                    res_nu_reg  <= 24'(nu_reg >> ASHIFT);
                    res_rad_reg <= rad_reg;
                    res_px_reg  <= px_reg;
                    res_py_reg  <= py_reg;
                    res_pz_reg  <= pz_reg;
                end
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // Ports
    // ---------------------------------------------------------------
    assign elements.ready             = (state_reg == ST_IDLE);
    assign position.valid             = out_vld_reg;
    assign position.eccentric_anomaly = res_ea_reg;
    assign position.true_anomaly      = res_nu_reg;
    assign position.radius            = res_rad_reg;
    assign position.pos_x             = res_px_reg;
    assign position.pos_y             = res_py_reg;
    assign position.pos_z             = res_pz_reg;

    assign pready = 1'b1;

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_NEWTON_THRESHOLD: prdata = {8'b0, thr_reg};
            REG_CONVERGE_LIMIT:   prdata = {16'b0, lim_cfg_reg};
            REG_MAX_ITERATIONS:   prdata = {28'b0, maxit_reg};
            default:              prdata = 32'd0;
        endcase
    end

endmodule

FILE: rtl/kop_checker.sv
// Port-level checks of the orbit position block, attached by bind.
// Depends on kepler_orbit_position, kop_in_if and kop_out_if.
module kop_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [23:0]        eccentric_anomaly,
    input logic [23:0]        true_anomaly,
    input logic [32:0]        radius,
    input logic signed [32:0] pos_x,
    input logic signed [32:0] pos_y,
    input logic signed [32:0] pos_z
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(eccentric_anomaly)
            && $stable(true_anomaly) && $stable(radius) && $stable(pos_x)
            && $stable(pos_y) && $stable(pos_z))
        else $error("stalled result changed");

    // drop ready once an item is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after an accepted item");

    // a new result appears only as the sequencer returns to idle
    a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result raised while busy");

    // no result can come out in the cycle after an accepted item
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared too early");

endmodule

bind kepler_orbit_position kop_checker u_kop_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (elements.valid),
    .in_ready          (elements.ready),
    .out_valid         (position.valid),
    .out_ready         (position.ready),
    .eccentric_anomaly (position.eccentric_anomaly),
    .true_anomaly      (position.true_anomaly),
    .radius            (position.radius),
    .pos_x             (position.pos_x),
    .pos_y             (position.pos_y),
    .pos_z             (position.pos_z)
);
